// ===== rtl/per_group_tile_insertion_binner_defines.svh =====
// Assertion macros used by the binner top level.
`ifndef PER_GROUP_TILE_INSERTION_BINNER_DEFINES_SVH
`define PER_GROUP_TILE_INSERTION_BINNER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PTIB_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PTIB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/ptib_pkg.sv =====
// Package with widths, codes and types of the per-group tile insertion binner.
`default_nettype none

package ptib_pkg;

	localparam int COORD_W     = 32;
	localparam int COUNT_W     = 32;
	localparam int GROUP_W     = 4;
	localparam int MODE_W      = 2;
	localparam int GROUP_COUNT = 16;
	localparam int GROUP_IDX_W = (GROUP_COUNT > 1) ? $clog2(GROUP_COUNT) : 1;
	localparam int DIV_CNT_W   = $clog2(COORD_W);

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] CFG_TILE_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_INSERT_MODE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_CLIP_END    = 2'd2;

	localparam logic [MODE_W-1:0] MODE_BOTH   = 2'd0;
	localparam logic [MODE_W-1:0] MODE_STARTS = 2'd1;
	localparam logic [MODE_W-1:0] MODE_ENDS   = 2'd2;

	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_FLUSH  = 1'b1;

	typedef struct packed {
		logic               start;
		logic [COORD_W-1:0] coord;
		logic [COORD_W-1:0] width;
	} div_req_t;

	typedef struct packed {
		logic               done;
		logic [COORD_W-1:0] tile_start;
	} div_rsp_t;

endpackage

`default_nettype wire

// ===== rtl/ptib_if.sv =====
// Valid/ready channel interfaces for insertion items and reported tiles.
`default_nettype none

interface ptib_item_if;
	logic                             valid;
	logic                             ready;
	logic                             operation;
	logic [ptib_pkg::COORD_W-1:0]     coord;
	logic [ptib_pkg::GROUP_W-1:0]     group;
	logic                             is_start;

	modport source (output valid, operation, coord, group, is_start, input ready);
	modport sink   (input valid, operation, coord, group, is_start, output ready);
endinterface

interface ptib_tile_if;
	logic                             valid;
	logic                             ready;
	logic [ptib_pkg::GROUP_W-1:0]     out_group;
	logic [ptib_pkg::COORD_W-1:0]     tile_start;
	logic [ptib_pkg::COORD_W-1:0]     tile_end;
	logic [ptib_pkg::COUNT_W-1:0]     tile_count;
	logic                             last;

	modport source (output valid, out_group, tile_start, tile_end, tile_count, last,
		input ready);
	modport sink   (input valid, out_group, tile_start, tile_end, tile_count, last,
		output ready);
endinterface

`default_nettype wire

// ===== rtl/ptib_tile_div.sv =====
// Bit-serial remainder unit that rounds a coordinate down to its tile start.
`default_nettype none

module ptib_tile_div (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire ptib_pkg::div_req_t  req,
	output ptib_pkg::div_rsp_t       rsp
);

	typedef enum logic [1:0] {
		D_IDLE,
		D_STEP,
		D_FIX
	} div_state_t;

	div_state_t                       state_q;
	logic [ptib_pkg::DIV_CNT_W-1:0]   cnt_q;
	logic                             done_q;
	logic [ptib_pkg::COORD_W-1:0]     coord_q;
	logic [ptib_pkg::COORD_W-1:0]     dvd_q;
	logic [ptib_pkg::COORD_W-1:0]     w_q;
	logic [ptib_pkg::COORD_W-1:0]     rem_q;
	logic [ptib_pkg::COORD_W-1:0]     start_q;

	logic [ptib_pkg::COORD_W:0]       rem_shift;
	logic [ptib_pkg::COORD_W:0]       op_a;
	logic [ptib_pkg::COORD_W:0]       op_b;
	logic [ptib_pkg::COORD_W:0]       diff;

	// One subtractor serves both the restoring steps and the final correction.
	always_comb begin
		rem_shift = {rem_q, dvd_q[ptib_pkg::COORD_W-1]};
		if (state_q == D_FIX) begin
			op_a = {1'b0, coord_q};
			op_b = {1'b0, rem_q};
		end else begin
			op_a = rem_shift;
			op_b = {1'b0, w_q};
		end
		diff = op_a - op_b;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= D_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				D_IDLE: begin
					if (req.start) begin
						cnt_q   <= '0;
						state_q <= D_STEP;
					end
				end
				D_STEP: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == ptib_pkg::DIV_CNT_W'(ptib_pkg::COORD_W - 1)) begin
						state_q <= D_FIX;
					end
				end
				D_FIX: begin
					done_q  <= 1'b1;
					state_q <= D_IDLE;
				end
				default: state_q <= D_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			D_IDLE: begin
				if (req.start) begin
					coord_q <= req.coord;
					dvd_q   <= req.coord;
					w_q     <= req.width;
					rem_q   <= '0;
				end
			end
			D_STEP: begin
				dvd_q <= {dvd_q[ptib_pkg::COORD_W-2:0], 1'b0};
				rem_q <= diff[ptib_pkg::COORD_W] ? rem_shift[ptib_pkg::COORD_W-1:0]
					: diff[ptib_pkg::COORD_W-1:0];
			end
			D_FIX: begin
				start_q <= diff[ptib_pkg::COORD_W-1:0];
			end
			default: ;
		endcase
	end

	assign rsp.done       = done_q;
	assign rsp.tile_start = start_q;

endmodule

`default_nettype wire

// ===== rtl/per_group_tile_insertion_binner.sv =====
// Top level of the per-group tile insertion binner.
//
//   Channel  Dir  Beat                                           Handshake
//   items    in   operation, coord, group, is_start              valid/ready
//   tiles    out  out_group, tile_start, tile_end, tile_count,   valid/ready
//                 last
//   cfg      in   cfg_idx, cfg_data                              cfg_we only
//
// An insertion runs through the one-bit-per-cycle remainder unit, and also
// through S_ADD and S_EMIT when it reports the group's previous tile.
// A flush scans groups in order and reports each open tile via S_ADD and S_EMIT.
// Reset clears all groups and loads the register reset values.
// A stalled tiles beat holds the sequencer before the next report only.
`default_nettype none
`include "per_group_tile_insertion_binner_defines.svh"

module per_group_tile_insertion_binner (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_we,
	input  wire logic [ptib_pkg::CFG_IDX_W-1:0]      cfg_idx,
	input  wire logic [ptib_pkg::CFG_DATA_W-1:0]     cfg_data,
	ptib_item_if.sink                                items,
	ptib_tile_if.source                              tiles
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_DIV,
		S_CHECK,
		S_SCAN,
		S_ADD,
		S_EMIT
	} state_t;

	state_t                                 state_q;
	logic [ptib_pkg::COORD_W-1:0]           tile_width_q;
	logic [ptib_pkg::MODE_W-1:0]            insert_mode_q;
	logic [ptib_pkg::COORD_W-1:0]           clip_end_q;
	logic [ptib_pkg::GROUP_COUNT-1:0]       open_valid_q;
	logic [ptib_pkg::COORD_W-1:0]           open_start_q [ptib_pkg::GROUP_COUNT];
	logic [ptib_pkg::COUNT_W-1:0]           open_tally_q [ptib_pkg::GROUP_COUNT];
	logic [ptib_pkg::GROUP_IDX_W-1:0]       idx_q;
	logic                                   flush_q;
	logic                                   emit_last_q;
	logic [ptib_pkg::COORD_W-1:0]           ts_q;
	logic [ptib_pkg::COORD_W-1:0]           end_q;
	logic                                   out_valid_q;
	logic [ptib_pkg::GROUP_W-1:0]           out_group_q;
	logic [ptib_pkg::COORD_W-1:0]           out_start_q;
	logic [ptib_pkg::COORD_W-1:0]           out_end_q;
	logic [ptib_pkg::COUNT_W-1:0]           out_count_q;
	logic                                   out_last_q;

	logic                                   accept;
	logic                                   keep;
	logic                                   in_range;
	logic                                   ins_go;
	logic                                   out_free;
	logic                                   emit_load;
	logic                                   flush_end;
	logic                                   hit;
	logic [ptib_pkg::COORD_W-1:0]           eff_w;
	logic [ptib_pkg::COORD_W:0]             end_sum;
	logic [ptib_pkg::GROUP_COUNT-1:0]       ge_mask;
	logic [ptib_pkg::GROUP_COUNT-1:0]       gt_mask;
	logic                                   any_ge;
	logic                                   any_gt;
	ptib_pkg::div_req_t                     div_req;
	ptib_pkg::div_rsp_t                     div_rsp;

	always_comb begin
		eff_w = (tile_width_q == '0) ? ptib_pkg::COORD_W'(1) : tile_width_q;
		unique case (insert_mode_q)
			ptib_pkg::MODE_BOTH:   keep = 1'b1;
			ptib_pkg::MODE_STARTS: keep = items.is_start;
			default:               keep = !items.is_start;
		endcase
		in_range  = int'(items.group) < ptib_pkg::GROUP_COUNT;
		accept    = items.valid && items.ready;
		ins_go    = accept && (items.operation == ptib_pkg::OP_INSERT) && keep && in_range;
		out_free  = !out_valid_q || tiles.ready;
		emit_load = (state_q == S_EMIT) && out_free;
		flush_end = emit_load && flush_q && emit_last_q;
		hit       = open_valid_q[idx_q] && (open_start_q[idx_q] == ts_q);
		end_sum   = {1'b0, open_start_q[idx_q]} + {1'b0, eff_w};
		for (int i = 0; i < ptib_pkg::GROUP_COUNT; i++) begin
			ge_mask[i] = i >= int'(idx_q);
			gt_mask[i] = i > int'(idx_q);
		end
		any_ge = |(open_valid_q & ge_mask);
		any_gt = |(open_valid_q & gt_mask);
	end

	assign items.ready = (state_q == S_IDLE);

	assign div_req.start = ins_go;
	assign div_req.coord = items.coord;
	assign div_req.width = eff_w;

	ptib_tile_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			tile_width_q  <= ptib_pkg::COORD_W'(1);
			insert_mode_q <= ptib_pkg::MODE_BOTH;
			clip_end_q    <= '1;
			open_valid_q  <= '0;
			idx_q         <= '0;
			flush_q       <= 1'b0;
			emit_last_q   <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_idx)
					ptib_pkg::CFG_TILE_WIDTH:  tile_width_q  <= cfg_data;
					ptib_pkg::CFG_INSERT_MODE: insert_mode_q <= cfg_data[ptib_pkg::MODE_W-1:0];
					ptib_pkg::CFG_CLIP_END:    clip_end_q    <= cfg_data;
					default: ;
				endcase
			end
			if (emit_load) begin
				out_valid_q <= 1'b1;
			end else if (tiles.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept && items.operation == ptib_pkg::OP_FLUSH) begin
						flush_q <= 1'b1;
						idx_q   <= '0;
						state_q <= S_SCAN;
					end else if (ins_go) begin
						flush_q <= 1'b0;
						idx_q   <= ptib_pkg::GROUP_IDX_W'(items.group);
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					if (div_rsp.done) begin
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					if (hit) begin
						state_q <= S_IDLE;
					end else if (open_valid_q[idx_q]) begin
						emit_last_q <= 1'b1;
						state_q     <= S_ADD;
					end else begin
						open_valid_q[idx_q] <= 1'b1;
						state_q             <= S_IDLE;
					end
				end
				S_SCAN: begin
					if (!any_ge) begin
						open_valid_q <= '0;
						state_q      <= S_IDLE;
					end else if (open_valid_q[idx_q]) begin
						emit_last_q <= !any_gt;
						state_q     <= S_ADD;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				S_ADD: begin
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (out_free) begin
						if (!flush_q) begin
							state_q <= S_IDLE;
						end else if (emit_last_q) begin
							open_valid_q <= '0;
							state_q      <= S_IDLE;
						end else begin
							idx_q   <= idx_q + 1'b1;
							state_q <= S_SCAN;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DIV && div_rsp.done) begin
			ts_q <= div_rsp.tile_start;
		end
		if (state_q == S_CHECK) begin
			if (hit) begin
				if (open_tally_q[idx_q] != '1) begin
					open_tally_q[idx_q] <= open_tally_q[idx_q] + 1'b1;
				end
			end else if (!open_valid_q[idx_q]) begin
				open_start_q[idx_q] <= ts_q;
				open_tally_q[idx_q] <= ptib_pkg::COUNT_W'(1);
			end
		end
		if (state_q == S_ADD) begin
			end_q <= end_sum[ptib_pkg::COORD_W] ? '1 : end_sum[ptib_pkg::COORD_W-1:0];
		end
		if (emit_load) begin
			out_group_q <= ptib_pkg::GROUP_W'(idx_q);
			out_start_q <= open_start_q[idx_q];
			out_end_q   <= (end_q > clip_end_q) ? clip_end_q : end_q;
			out_count_q <= open_tally_q[idx_q];
			out_last_q  <= emit_last_q;
			if (!flush_q) begin
				open_start_q[idx_q] <= ts_q;
				open_tally_q[idx_q] <= ptib_pkg::COUNT_W'(1);
			end
		end
	end

	assign tiles.valid      = out_valid_q;
	assign tiles.out_group  = out_group_q;
	assign tiles.tile_start = out_start_q;
	assign tiles.tile_end   = out_end_q;
	assign tiles.tile_count = out_count_q;
	assign tiles.last       = out_last_q;

	`PTIB_ASSERT_SAME(a_div_done, clk, arst_n, div_rsp.done, state_q == S_DIV, "Stray divide.")
	`PTIB_ASSERT_SAME(a_emit_ok, clk, arst_n, state_q == S_EMIT, open_valid_q[idx_q], "No tile.")
	`PTIB_ASSERT_NEXT(a_flush_clr, clk, arst_n, flush_end, open_valid_q == '0, "Groups open.")

endmodule

`default_nettype wire
